>>> rtl/core/arrival_steering_step_top_macros.svh
// assertion helpers for the arrival steering pipeline
`ifndef ARRIVAL_STEERING_STEP_TOP_MACROS_SVH
`define ARRIVAL_STEERING_STEP_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define AST_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define AST_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ast_pkg.sv
package ast_pkg;

    localparam int SQRT_LAT = 32;
    localparam int DIV_QW   = 18;
    localparam int DIV_LAT  = DIV_QW;
    localparam int DIV_NW   = 49;
    localparam int DIV_DW   = 33;

    // stage numbers, stage 0 is the input register
    localparam int S_ROOT = 3 + SQRT_LAT;
    localparam int S_DIV  = S_ROOT + 1;
    localparam int S_Q    = S_DIV + DIV_LAT;
    localparam int S_OUT  = S_Q + 10;
    localparam int GEO_N  = S_OUT - 1;

    localparam int CFG_IW = 2;
    localparam logic [30:0] RADIUS_RST = 31'd655360;
    localparam logic [17:0] UNIT_ONE   = 18'd65536;

    typedef enum logic [CFG_IW-1:0] {
        REG_TGT_X  = 2'd0,
        REG_TGT_Y  = 2'd1,
        REG_RADIUS = 2'd2,
        REG_WEIGHT = 2'd3
    } t_reg;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [30:0]        ms;
        logic [16:0]        dt;
    } t_ctx;

    typedef struct packed {
        t_ctx        c;
        logic [31:0] ax;
        logic [31:0] ay;
        logic        dxn;
        logic        dyn;
        logic        big;
    } t_geo;

endpackage

>>> rtl/core/ast_div_pipe.sv
module ast_div_pipe (
    input  logic                        i_clk,
    input  logic [ast_pkg::DIV_NW-1:0]  i_num,
    input  logic [ast_pkg::DIV_DW-1:0]  i_den,
    output logic [ast_pkg::DIV_QW-1:0]  o_quo
);
    import ast_pkg::*;

    localparam int CW = DIV_DW + DIV_QW;

    logic [DIV_NW-1:0] r_rem [DIV_LAT];
    logic [DIV_DW-1:0] r_den [DIV_LAT];
    logic [DIV_QW-1:0] r_quo [DIV_LAT];

    // restoring division, one quotient bit per stage, msb first
    for (genvar t = 0; t < DIV_LAT; t++) begin : g_stg
        localparam int SH = DIV_QW - 1 - t;
        logic [DIV_NW-1:0] n_rem;
        logic [DIV_DW-1:0] n_den;
        logic [DIV_QW-1:0] n_quo;
        logic [CW-1:0]     n_trial;

        if (t == 0) begin : g_head
            assign n_rem = i_num;
            assign n_den = i_den;
            assign n_quo = '0;
        end else begin : g_body
            assign n_rem = r_rem[t-1];
            assign n_den = r_den[t-1];
            assign n_quo = r_quo[t-1];
        end

        assign n_trial = CW'(n_den) << SH;

        always_ff @(posedge i_clk) begin
            r_den[t] <= n_den;
            if (CW'(n_rem) >= n_trial) begin
                r_rem[t] <= n_rem - n_trial[DIV_NW-1:0];
                r_quo[t] <= n_quo | (DIV_QW'(1) << SH);
            end else begin
                r_rem[t] <= n_rem;
                r_quo[t] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];

endmodule

>>> rtl/core/arrival_steering_step_top.sv
// channel   direction  handshake              payload
// item in   in         start & !busy          i_pos_x/y, i_vel_x/y, i_max_speed, i_delta_time
// result    out        o_done, one cycle      o_new_pos_x/y, o_new_vel_x/y, o_accel_x/y,
//                                             o_accel_valid
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// one item per cycle, results leave in the order the items were accepted
// pipeline depth is set by the 32-stage bit-per-stage square roots and the 18-stage dividers
// busy stays low: the pipeline never stalls, the receiver takes every result
// synchronous active-low reset acts on valid bits and config registers only, radius goes to 655360
module arrival_steering_step_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           i_pos_x,
    input  logic signed [31:0]           i_pos_y,
    input  logic signed [31:0]           i_vel_x,
    input  logic signed [31:0]           i_vel_y,
    input  logic [30:0]                  i_max_speed,
    input  logic [16:0]                  i_delta_time,
    input  logic                         i_cfg_we,
    input  logic [ast_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    output logic                         o_done,
    output logic signed [31:0]           o_new_pos_x,
    output logic signed [31:0]           o_new_pos_y,
    output logic signed [31:0]           o_new_vel_x,
    output logic signed [31:0]           o_new_vel_y,
    output logic signed [31:0]           o_accel_x,
    output logic signed [31:0]           o_accel_y,
    output logic                         o_accel_valid
);
    import ast_pkg::*;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] x);
        logic signed [32:0] w;
        w = 33'(x);
        return x[31] ? 32'(-w) : x[31:0];
    endfunction

    function automatic logic signed [17:0] f_unit(input logic [17:0] q, input logic zero,
                                                  input logic neg);
        logic [17:0] m;
        m = (q > UNIT_ONE) ? UNIT_ONE : q;
        if (zero) begin
            m = '0;
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // config registers
    logic signed [31:0] r_tgt_x, r_tgt_y;
    logic [30:0]        r_radius;
    logic [20:0]        r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_radius <= RADIUS_RST;
            r_weight <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_TGT_X:  r_tgt_x  <= $signed(i_cfg_data);
                REG_TGT_Y:  r_tgt_y  <= $signed(i_cfg_data);
                REG_RADIUS: r_radius <= i_cfg_data[30:0];
                REG_WEIGHT: r_weight <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [S_OUT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_OUT-1:0], start & ~busy};
        end
    end

    // front: differences, magnitudes, squares
    t_ctx               r_in;
    t_geo               r_geo [GEO_N];
    logic signed [32:0] n_dx, n_dy;
    logic [31:0]        n_ax, n_ay, n_hx, n_hy;
    logic [63:0]        r_sq [4];
    logic [63:0]        r_sd, r_sv;

    assign n_dx = 33'(r_tgt_x) - 33'(r_in.px);
    assign n_dy = 33'(r_tgt_y) - 33'(r_in.py);
    assign n_ax = n_dx[32] ? 32'(-n_dx) : n_dx[31:0];
    assign n_ay = n_dy[32] ? 32'(-n_dy) : n_dy[31:0];
    // halve both when either no longer fits 31 bits
    assign n_hx = r_geo[0].big ? (r_geo[0].ax >> 1) : r_geo[0].ax;
    assign n_hy = r_geo[0].big ? (r_geo[0].ay >> 1) : r_geo[0].ay;

    always_ff @(posedge i_clk) begin
        r_in.px <= i_pos_x;
        r_in.py <= i_pos_y;
        r_in.vx <= i_vel_x;
        r_in.vy <= i_vel_y;
        r_in.ms <= i_max_speed;
        r_in.dt <= i_delta_time;
        r_geo[0].c   <= r_in;
        r_geo[0].ax  <= n_ax;
        r_geo[0].ay  <= n_ay;
        r_geo[0].dxn <= n_dx[32];
        r_geo[0].dyn <= n_dy[32];
        r_geo[0].big <= n_ax[31] | n_ay[31];
        for (int k = 1; k < GEO_N; k++) begin
            r_geo[k] <= r_geo[k-1];
        end
        r_sq[0] <= 64'(n_hx) * 64'(n_hx);
        r_sq[1] <= 64'(n_hy) * 64'(n_hy);
        r_sq[2] <= 64'(f_mag(r_geo[0].c.vx)) * 64'(f_mag(r_geo[0].c.vx));
        r_sq[3] <= 64'(f_mag(r_geo[0].c.vy)) * 64'(f_mag(r_geo[0].c.vy));
        r_sd <= r_sq[0] + r_sq[1];
        r_sv <= r_sq[2] + r_sq[3];
    end

    // two square-root lanes, distance and speed, one result bit per stage
    logic [63:0] r_sqv [2][SQRT_LAT];
    logic [63:0] r_sqr [2][SQRT_LAT];
    logic [63:0] n_sq_in [2];

    assign n_sq_in[0] = r_sd;
    assign n_sq_in[1] = r_sv;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar t = 0; t < SQRT_LAT; t++) begin : g_stg
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * t);
            logic [63:0] n_v, n_r, n_try;

            if (t == 0) begin : g_head
                assign n_v = n_sq_in[l];
                assign n_r = '0;
            end else begin : g_body
                assign n_v = r_sqv[l][t-1];
                assign n_r = r_sqr[l][t-1];
            end

            assign n_try = n_r + BIT;

            always_ff @(posedge i_clk) begin
                if (n_v >= n_try) begin
                    r_sqv[l][t] <= n_v - n_try;
                    r_sqr[l][t] <= (n_r >> 1) + BIT;
                end else begin
                    r_sqv[l][t] <= n_v;
                    r_sqr[l][t] <= n_r >> 1;
                end
            end
        end
    end

    // lengths and the inside test
    logic [32:0] n_dist, r_dist;
    logic [31:0] r_vlen;
    logic        r_ins [DIV_LAT+1];
    t_geo        n_g36;

    assign n_dist = r_geo[S_ROOT-1].big ? {r_sqr[0][SQRT_LAT-1][31:0], 1'b0}
                                        : {1'b0, r_sqr[0][SQRT_LAT-1][31:0]};
    assign n_g36  = r_geo[S_DIV-1];

    always_ff @(posedge i_clk) begin
        r_dist   <= n_dist;
        r_vlen   <= r_sqr[1][SQRT_LAT-1][31:0];
        r_ins[0] <= n_dist < 33'(r_radius);
        for (int k = 1; k <= DIV_LAT; k++) begin
            r_ins[k] <= r_ins[k-1];
        end
    end

    logic [DIV_QW-1:0] n_q_ux, n_q_uy, n_q_vx, n_q_vy, n_q_sc;

    ast_div_pipe u_div_ux (.i_clk(i_clk), .i_num(DIV_NW'({n_g36.ax, 16'b0})),
                           .i_den(r_dist), .o_quo(n_q_ux));
    ast_div_pipe u_div_uy (.i_clk(i_clk), .i_num(DIV_NW'({n_g36.ay, 16'b0})),
                           .i_den(r_dist), .o_quo(n_q_uy));
    ast_div_pipe u_div_vx (.i_clk(i_clk), .i_num(DIV_NW'({f_mag(n_g36.c.vx), 16'b0})),
                           .i_den(DIV_DW'(r_vlen)), .o_quo(n_q_vx));
    ast_div_pipe u_div_vy (.i_clk(i_clk), .i_num(DIV_NW'({f_mag(n_g36.c.vy), 16'b0})),
                           .i_den(DIV_DW'(r_vlen)), .o_quo(n_q_vy));
    ast_div_pipe u_div_sc (.i_clk(i_clk), .i_num({r_dist, 16'b0}),
                           .i_den(DIV_DW'(r_radius)), .o_quo(n_q_sc));

    // steering arithmetic, the products split over successive stages
    t_geo               n_g54;
    logic signed [17:0] r_ux, r_uy, r_vnx, r_vny;
    logic [16:0]        r_sc55, r_sc56;
    logic               r_ins55, r_ins56, r_ins57, r_ins58, r_ins59, r_ins60, r_ins61;
    logic               r_ins62, r_ins63;
    logic signed [31:0] n_ms;
    logic signed [49:0] n_mx, n_my;
    logic signed [31:0] r_ax0_x, r_ax0_y, r_ax1_x, r_ax1_y, r_ax2_x, r_ax2_y;
    logic signed [35:0] r_pcx, r_pcy;
    logic signed [36:0] n_csum;
    logic signed [20:0] n_csh;
    logic signed [17:0] r_cs;
    logic signed [49:0] n_asx, n_asy;
    logic signed [33:0] r_acs_x, r_acs_y, r_acs2_x, r_acs2_y;
    logic signed [49:0] r_bx, r_by;
    logic signed [51:0] n_brx, n_bry;
    logic signed [52:0] n_accx, n_accy;
    logic signed [31:0] n_acx, n_acy;
    logic signed [31:0] r_ac59_x, r_ac59_y, r_ac60_x, r_ac60_y, r_ac61_x, r_ac61_y;
    logic signed [31:0] r_ac62_x, r_ac62_y, r_ac63_x, r_ac63_y;
    logic signed [33:0] r_sx, r_sy;
    logic signed [55:0] n_wmx, n_wmy;
    logic signed [39:0] r_wx, r_wy;
    logic signed [57:0] r_dmx, r_dmy;
    logic signed [42:0] n_nvx, n_nvy;
    logic signed [31:0] r_nvx, r_nvy, r_nv63_x, r_nv63_y;
    logic signed [49:0] r_pmx, r_pmy;
    logic signed [34:0] n_npx, n_npy;

    assign n_g54 = r_geo[S_Q-1];
    assign n_ms  = $signed({1'b0, r_geo[S_Q].c.ms});
    assign n_mx  = r_ux * n_ms;
    assign n_my  = r_uy * n_ms;
    assign n_csum = 37'(r_pcx) + 37'(r_pcy);
    assign n_csh  = 21'(n_csum >>> 16);
    assign n_asx = r_ax0_x * $signed({1'b0, r_sc56});
    assign n_asy = r_ax0_y * $signed({1'b0, r_sc56});
    // braking term: minus twice velocity times cosine
    assign n_brx = (-(52'(r_bx) <<< 1)) >>> 16;
    assign n_bry = (-(52'(r_by) <<< 1)) >>> 16;
    assign n_accx = 53'(r_acs2_x) + 53'(n_brx);
    assign n_accy = 53'(r_acs2_y) + 53'(n_bry);
    assign n_acx = r_ins58 ? f_sat32(64'(n_accx)) : r_ax2_x;
    assign n_acy = r_ins58 ? f_sat32(64'(n_accy)) : r_ax2_y;
    assign n_wmx = r_sx * $signed({1'b0, r_weight});
    assign n_wmy = r_sy * $signed({1'b0, r_weight});
    assign n_nvx = 43'(r_geo[S_Q+6].c.vx) + 43'(r_dmx >>> 16);
    assign n_nvy = 43'(r_geo[S_Q+6].c.vy) + 43'(r_dmy >>> 16);
    assign n_npx = 35'(r_geo[S_Q+8].c.px) + 35'(r_pmx >>> 16);
    assign n_npy = 35'(r_geo[S_Q+8].c.py) + 35'(r_pmy >>> 16);

    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_ax, r_o_ay;
    logic               r_o_av;

    always_ff @(posedge i_clk) begin
        // unit vectors and scale
        r_ux    <= f_unit(n_q_ux, (n_g54.ax == '0) && (n_g54.ay == '0), n_g54.dxn);
        r_uy    <= f_unit(n_q_uy, (n_g54.ax == '0) && (n_g54.ay == '0), n_g54.dyn);
        r_vnx   <= f_unit(n_q_vx, (n_g54.c.vx == '0) && (n_g54.c.vy == '0), n_g54.c.vx[31]);
        r_vny   <= f_unit(n_q_vy, (n_g54.c.vx == '0) && (n_g54.c.vy == '0), n_g54.c.vy[31]);
        r_sc55  <= n_q_sc[16:0];
        r_ins55 <= r_ins[DIV_LAT];
        // desired acceleration at top speed, cosine products
        r_ax0_x <= 32'(n_mx >>> 16);
        r_ax0_y <= 32'(n_my >>> 16);
        r_pcx   <= r_ux * r_vnx;
        r_pcy   <= r_uy * r_vny;
        r_sc56  <= r_sc55;
        r_ins56 <= r_ins55;
        // clamped cosine, distance scaling
        if (n_csh > 21'sd65536) begin
            r_cs <= 18'sd65536;
        end else if (n_csh < -21'sd65536) begin
            r_cs <= -18'sd65536;
        end else begin
            r_cs <= n_csh[17:0];
        end
        r_acs_x <= 34'(n_asx >>> 16);
        r_acs_y <= 34'(n_asy >>> 16);
        r_ax1_x <= r_ax0_x;
        r_ax1_y <= r_ax0_y;
        r_ins57 <= r_ins56;
        // cosine times velocity
        r_bx     <= r_cs * r_geo[S_Q+2].c.vx;
        r_by     <= r_cs * r_geo[S_Q+2].c.vy;
        r_acs2_x <= r_acs_x;
        r_acs2_y <= r_acs_y;
        r_ax2_x  <= r_ax1_x;
        r_ax2_y  <= r_ax1_y;
        r_ins58  <= r_ins57;
        // final acceleration, steering force
        r_ac59_x <= n_acx;
        r_ac59_y <= n_acy;
        r_sx     <= 34'(n_acx) - 34'(r_geo[S_Q+3].c.vx);
        r_sy     <= 34'(n_acy) - 34'(r_geo[S_Q+3].c.vy);
        r_ins59  <= r_ins58;
        // weight of zero leaves the force as is
        r_wx     <= (r_weight != '0) ? 40'(n_wmx >>> 16) : 40'(r_sx);
        r_wy     <= (r_weight != '0) ? 40'(n_wmy >>> 16) : 40'(r_sy);
        r_ac60_x <= r_ac59_x;
        r_ac60_y <= r_ac59_y;
        r_ins60  <= r_ins59;
        // velocity integration
        r_dmx    <= r_wx * $signed({1'b0, r_geo[S_Q+5].c.dt});
        r_dmy    <= r_wy * $signed({1'b0, r_geo[S_Q+5].c.dt});
        r_ac61_x <= r_ac60_x;
        r_ac61_y <= r_ac60_y;
        r_ins61  <= r_ins60;
        r_nvx    <= f_sat32(64'(n_nvx));
        r_nvy    <= f_sat32(64'(n_nvy));
        r_ac62_x <= r_ac61_x;
        r_ac62_y <= r_ac61_y;
        r_ins62  <= r_ins61;
        // position integration
        r_pmx    <= r_nvx * $signed({1'b0, r_geo[S_Q+7].c.dt});
        r_pmy    <= r_nvy * $signed({1'b0, r_geo[S_Q+7].c.dt});
        r_nv63_x <= r_nvx;
        r_nv63_y <= r_nvy;
        r_ac63_x <= r_ac62_x;
        r_ac63_y <= r_ac62_y;
        r_ins63  <= r_ins62;
        // output register
        r_o_px <= f_sat32(64'(n_npx));
        r_o_py <= f_sat32(64'(n_npy));
        r_o_vx <= r_nv63_x;
        r_o_vy <= r_nv63_y;
        r_o_ax <= r_ins63 ? r_ac63_x : '0;
        r_o_ay <= r_ins63 ? r_ac63_y : '0;
        r_o_av <= r_ins63;
    end

    assign o_done        = r_vld[S_OUT];
    assign o_new_pos_x   = r_o_px;
    assign o_new_pos_y   = r_o_py;
    assign o_new_vel_x   = r_o_vx;
    assign o_new_vel_y   = r_o_vy;
    assign o_accel_x     = r_o_ax;
    assign o_accel_y     = r_o_ay;
    assign o_accel_valid = r_o_av & r_vld[S_OUT];

`include "arrival_steering_step_top_macros.svh"

    `AST_CHECK(a_done_latency, o_done, $past(start && !busy, S_OUT + 1), "result without item")
    `AST_CHECK(a_accel_zero, o_done && !o_accel_valid, {o_accel_x, o_accel_y} == '0, "accel set")

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ast_pkg::*;

    localparam int LATENCY   = 65;
    localparam int N_RANDOM  = 1500;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [30:0]        ms;
        logic [16:0]        dt;
    } t_agent;

    typedef struct {
        logic signed [31:0] npx, npy, nvx, nvy, acx, acy;
        logic               acv;
    } t_motion;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic [30:0] i_max_speed = '0;
    logic [16:0] i_delta_time = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = REG_TGT_X;
    logic [31:0] i_cfg_data = '0;
    logic o_done;
    logic signed [31:0] o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y;
    logic signed [31:0] o_accel_x, o_accel_y;
    logic o_accel_valid;

    arrival_steering_step_top DUT (.*);

    // copy of the config registers
    longint tgt_x = 0, tgt_y = 0, radius = 655360, wgt = 0;

    t_agent  pending_agents[$];
    t_motion expected_motion[$];
    int errors = 0;
    bit idle_ok = 1'b1;
    bit drain = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_one(longint x);
        if (x > 65536) return 65536;
        if (x < -65536) return -65536;
        return x;
    endfunction

    function automatic longint qshift(longint x);
        return x >>> 16;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unit_comp(longint c, longint len);
        if (len == 0) return 0;
        return clamp_one((c * 65536) / len);
    endfunction

    function automatic longint absval(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic t_motion steer(t_agent a);
        t_motion m;
        longint px, py, vx, vy, ms, dt, dx, dy, mx, my, dist_q, ux, uy, acx, acy;
        longint sc, vlen, vnx, vny, cs, sx, sy, nvx, nvy;
        bit in_radius;
        px = a.px; py = a.py; vx = a.vx; vy = a.vy;
        ms = longint'(a.ms); dt = longint'(a.dt);
        dx = tgt_x - px; dy = tgt_y - py;
        mx = absval(dx); my = absval(dy);
        // far-apart points: halve before squaring to stay within 64 bits
        if (mx >= 64'sh80000000 || my >= 64'sh80000000)
            dist_q = int_root((mx >> 1) * (mx >> 1) + (my >> 1) * (my >> 1)) << 1;
        else
            dist_q = int_root(mx * mx + my * my);
        ux = unit_comp(dx, dist_q);
        uy = unit_comp(dy, dist_q);
        acx = qshift(ux * ms);
        acy = qshift(uy * ms);
        in_radius = dist_q < radius;
        if (in_radius) begin
            sc = (dist_q * 65536) / radius;
            vlen = int_root(absval(vx) * absval(vx) + absval(vy) * absval(vy));
            vnx = unit_comp(vx, vlen);
            vny = unit_comp(vy, vlen);
            cs = clamp_one(qshift(ux * vnx + uy * vny));
            acx = sat32(qshift(acx * sc) + qshift(-(2 * cs * vx)));
            acy = sat32(qshift(acy * sc) + qshift(-(2 * cs * vy)));
        end
        sx = acx - vx; sy = acy - vy;
        if (wgt > 0) begin
            sx = qshift(sx * wgt);
            sy = qshift(sy * wgt);
        end
        nvx = sat32(vx + qshift(sx * dt));
        nvy = sat32(vy + qshift(sy * dt));
        m.nvx = nvx[31:0];
        m.nvy = nvy[31:0];
        m.npx = 32'(sat32(px + qshift(nvx * dt)));
        m.npy = 32'(sat32(py + qshift(nvy * dt)));
        m.acx = in_radius ? acx[31:0] : '0;
        m.acy = in_radius ? acy[31:0] : '0;
        m.acv = in_radius;
        return m;
    endfunction

    // driver
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (i_rst_n && pending_agents.size() > 0 && !i_cfg_we) begin
            if (idle_ok && $urandom_range(0, 9) == 0) begin
                gap_left <= $urandom_range(0, 14);
                start <= 1'b0;
            end else begin
                i_pos_x <= pending_agents[0].px;
                i_pos_y <= pending_agents[0].py;
                i_vel_x <= pending_agents[0].vx;
                i_vel_y <= pending_agents[0].vy;
                i_max_speed <= pending_agents[0].ms;
                i_delta_time <= pending_agents[0].dt;
                start <= 1'b1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // acceptance and result check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            t_agent a;
            a = pending_agents.pop_front();
            expected_motion.push_back(steer(a));
        end
        if (i_rst_n && o_done) begin
            t_motion e;
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected result", $realtime);
                errors++;
            end else begin
                e = expected_motion.pop_front();
                if (o_new_pos_x !== e.npx || o_new_pos_y !== e.npy ||
                    o_new_vel_x !== e.nvx || o_new_vel_y !== e.nvy ||
                    o_accel_x !== e.acx || o_accel_y !== e.acy ||
                    o_accel_valid !== e.acv) begin
                    $display("%0t: mismatch exp pos %0d %0d vel %0d %0d acc %0d %0d %0b",
                             $realtime, e.npx, e.npy, e.nvx, e.nvy, e.acx, e.acy, e.acv);
                    $display("%0t:          got pos %0d %0d vel %0d %0d acc %0d %0d %0b",
                             $realtime, o_new_pos_x, o_new_pos_y, o_new_vel_x,
                             o_new_vel_y, o_accel_x, o_accel_y, o_accel_valid);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(t_reg idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_TGT_X:  tgt_x = longint'(signed'(data));
            REG_TGT_Y:  tgt_y = longint'(signed'(data));
            REG_RADIUS: radius = longint'(data[30:0]);
            REG_WEIGHT: wgt = longint'(data[20:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_agents.size() > 0 || expected_motion.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 65536 * 20)) - 32'(65536 * 10);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_agent near_agent(int spread);
        t_agent a;
        a.px = 32'(tgt_x) + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
        a.py = 32'(tgt_y) + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
        a.vx = $urandom_range(0, 3) == 0 ? rand_word() :
               32'($urandom_range(0, 65536 * 8)) - 32'(65536 * 4);
        a.vy = $urandom_range(0, 3) == 0 ? rand_word() :
               32'($urandom_range(0, 65536 * 8)) - 32'(65536 * 4);
        a.ms = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 65536 * 16));
        a.dt = $urandom_range(0, 7) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 65536));
        return a;
    endfunction

    function automatic t_agent wild_agent();
        t_agent a;
        a.px = rand_word(); a.py = rand_word();
        a.vx = rand_word(); a.vy = rand_word();
        a.ms = 31'($urandom()); a.dt = 17'($urandom());
        return a;
    endfunction

    task automatic push_agent(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                              logic [31:0] vy, logic [30:0] ms, logic [16:0] dt);
        t_agent a;
        a.px = px; a.py = py; a.vx = vx; a.vy = vy; a.ms = ms; a.dt = dt;
        pending_agents.push_back(a);
    endtask

    task automatic random_batch(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0)
                pending_agents.push_back(near_agent($urandom_range(0, 1) ?
                                         int'(radius < 2000000 ? radius : 2000000) + 10
                                         : 65536 * 4));
            else
                pending_agents.push_back(wild_agent());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: agent on the target, zero velocity, extremes, outside radius
        push_agent(0, 0, 0, 0, 31'd65536, 17'd65536);
        push_agent(0, 0, 32'd65536, 0, 31'd65536, 17'd32768);
        push_agent(32'd65536, 32'd65536, 0, 0, 31'd131072, 17'd65536);
        push_agent(32'd65536, 0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 17'h1ffff);
        push_agent(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                   31'h7fffffff, 17'd65536);
        push_agent(32'h80000000, 32'h80000000, 0, 0, 31'h7fffffff, 17'h1ffff);
        push_agent(32'd1000000, 32'hfff00000, 32'd5000, 32'hffff0000, 0, 0);
        push_agent(32'hffff0000, 32'd30000, 32'hffff0000, 32'd65536, 31'd65536, 17'd65536);
        wait_idle();
        write_reg(REG_WEIGHT, 32'd32768);
        write_reg(REG_TGT_X, 32'h7fffffff);
        write_reg(REG_TGT_Y, 32'h80000000);
        push_agent(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 31'h7fffffff, 17'd65536);
        push_agent(32'h7fffffff, 32'h80000000, 32'd65536, 32'd65536, 31'd65536, 17'd65536);
        random_batch(250);
        wait_idle();
        write_reg(REG_RADIUS, 32'h7fffffff);
        write_reg(REG_WEIGHT, 32'h1fffff);
        write_reg(REG_TGT_X, 32'd12345678);
        write_reg(REG_TGT_Y, 32'hff000000);
        random_batch(300);
        wait_idle();
        write_reg(REG_RADIUS, 32'd1);
        write_reg(REG_WEIGHT, 32'd1048576);
        write_reg(REG_TGT_X, rand_word());
        write_reg(REG_TGT_Y, rand_word());
        random_batch(300);
        wait_idle();
        write_reg(REG_RADIUS, 32'd3000000);
        write_reg(REG_WEIGHT, 32'd0);
        write_reg(REG_TGT_X, 32'h80000000);
        write_reg(REG_TGT_Y, 32'h7fffffff);
        random_batch(300);
        wait_idle();
        write_reg(REG_RADIUS, 32'd655360);
        write_reg(REG_WEIGHT, 32'd65536);
        write_reg(REG_TGT_X, 0);
        write_reg(REG_TGT_Y, 0);
        random_batch(200);
        // last stretch at full rate
        while (pending_agents.size() > 150) @(posedge i_clk);
        idle_ok = 1'b0;
        random_batch(150);
        wait_idle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ast_pkg.sv
rtl/core/ast_div_pipe.sv
rtl/core/arrival_steering_step_top.sv
bench/testbench.sv
